// ----- sv/sid_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the signed 32-bit divider.
// No dependencies.
package sid_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned CNT_W  = $clog2(DATA_W);

    localparam logic [DATA_W-1:0] SIGN_BIT = 32'h8000_0000;
    localparam logic [DATA_W-1:0] MAX_POS  = 32'h7FFF_FFFF;
    localparam logic [CNT_W-1:0]  LAST_BIT = CNT_W'(DATA_W - 1);

    typedef logic signed [DATA_W-1:0] t_word;

    // Divider sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_DONE
    } t_state;

    // Controls from the sequencer to the datapath
    typedef struct packed {
        logic req_ready;
        logic load;
        logic step;
        logic deliver;
    } t_ctrl;

endpackage

// ----- sv/sid_ifs.sv -----
`timescale 1ns / 1ps
// Valid/ready channels for the divider: request (operands) and response (quotient).
// Depends on sid_pkg.
interface sid_req_if;
    logic              valid;
    logic              ready;
    sid_pkg::t_word    numerator;
    sid_pkg::t_word    denominator;

    modport source (output valid, output numerator, output denominator, input ready);
    modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

interface sid_rsp_if;
    logic              valid;
    logic              ready;
    sid_pkg::t_word    quotient;
    logic              overflowed;
    logic              zero_divisor;

    modport source (output valid, output quotient, output overflowed, output zero_divisor,
                    input ready);
    modport sink   (input valid, input quotient, input overflowed, input zero_divisor,
                    output ready);
endinterface

// ----- sv/signed_int32_divider_unit.sv -----
`timescale 1ns / 1ps
// Signed 32-bit divider, radix-2 restoring, one quotient bit per cycle.
// The accept edge loads the operand magnitudes, then one shift/subtract step runs per quotient bit,
// and the sign-fixed result enters the output register once that register is free.
// Requests do not overlap: one is accepted only in idle, using the single shared subtractor loop;
// a finished response waits in its own register while the next request runs.
// Reset (i_rst_n, synchronous, active low) returns the sequencer to idle and drops o_rsp.valid.
// Depends on sid_pkg and sid_ifs.
module signed_int32_divider_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sid_req_if.sink    i_req,
    sid_rsp_if.source  o_rsp
);

    localparam int unsigned W = sid_pkg::DATA_W;

    sid_pkg::t_state r_state, n_state;
    sid_pkg::t_ctrl  ctrl;

    logic [sid_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [W-1:0] r_rem, n_rem;     // partial remainder
    logic [W-1:0] r_quo, n_quo;     // dividend bits shift out, quotient bits shift in
    logic [W-1:0] r_den;            // divisor magnitude
    logic         r_neg;
    logic         r_zero;

    logic         r_out_valid, n_out_valid;
    logic [W-1:0] r_out_q;
    logic         r_out_ovf;
    logic         r_out_zero;

    logic         out_free;
    logic [W-1:0] num_bits, den_bits;
    logic [W:0]   shifted;
    logic [W+1:0] diff;
    logic         ge;
    logic [W-1:0] q_signed;
    logic         ovf;

    assign out_free = !r_out_valid || o_rsp.ready;

    // Next-state logic
    always_comb begin
        n_state = r_state;
        case (r_state)
            sid_pkg::S_IDLE: begin
                if (i_req.valid) n_state = sid_pkg::S_CALC;
            end
            sid_pkg::S_CALC: begin
                if (r_cnt == sid_pkg::LAST_BIT) n_state = sid_pkg::S_DONE;
            end
            sid_pkg::S_DONE: begin
                if (out_free) n_state = sid_pkg::S_IDLE;
            end
            default: n_state = sid_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        ctrl = '0;
        case (r_state)
            sid_pkg::S_IDLE: begin
                ctrl.req_ready = 1'b1;
                ctrl.load      = i_req.valid;
            end
            sid_pkg::S_CALC: begin
                ctrl.step = 1'b1;
            end
            sid_pkg::S_DONE: begin
                ctrl.deliver = out_free;
            end
            default: ctrl = '0;
        endcase
    end

    assign i_req.ready = ctrl.req_ready;

    // Raw operands from the request
    assign num_bits = i_req.numerator;
    assign den_bits = i_req.denominator;

    // One restoring step: shift in next dividend bit, trial subtract
    assign shifted = {r_rem, r_quo[W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_den};
    assign ge      = !diff[W+1];

    // Sign fix and saturation on the finished quotient
    assign ovf      = !r_neg && r_quo[W-1];
    assign q_signed = r_neg ? (W'(0) - r_quo) : r_quo;

    always_comb begin
        n_cnt = r_cnt;
        n_rem = r_rem;
        n_quo = r_quo;
        if (ctrl.load) begin
            n_cnt = '0;
            n_rem = '0;
            n_quo = num_bits[W-1] ? (W'(0) - num_bits) : num_bits;
        end else if (ctrl.step) begin
            n_cnt = r_cnt + 1'b1;
            n_rem = ge ? diff[W-1:0] : shifted[W-1:0];
            n_quo = {r_quo[W-2:0], ge};
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (ctrl.deliver)    n_out_valid = 1'b1;
        else if (o_rsp.ready) n_out_valid = 1'b0;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sid_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (ctrl.load) begin
            r_den  <= den_bits[W-1] ? (W'(0) - den_bits) : den_bits;
            r_neg  <= num_bits[W-1] ^ den_bits[W-1];
            r_zero <= (den_bits == '0);
        end
    end

    // Response register
    always_ff @(posedge i_clk) begin
        if (ctrl.deliver) begin
            if (r_zero) begin
                r_out_q    <= '0;
                r_out_ovf  <= 1'b0;
                r_out_zero <= 1'b1;
            end else if (ovf) begin
                r_out_q    <= sid_pkg::MAX_POS;
                r_out_ovf  <= 1'b1;
                r_out_zero <= 1'b0;
            end else begin
                r_out_q    <= q_signed;
                r_out_ovf  <= 1'b0;
                r_out_zero <= 1'b0;
            end
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.quotient     = r_out_q;
    assign o_rsp.overflowed   = r_out_ovf;
    assign o_rsp.zero_divisor = r_out_zero;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for signed_int32_divider_unit: drives operand requests, predicts
// each quotient and compares it field by field. Depends on sid_pkg, sid_ifs and the RTL.
module testbench;

    localparam int unsigned CLK_HALF     = 6;
    localparam int unsigned RESET_CYCLES = 9;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned PHASE_ITEMS  = 184;

    localparam sid_pkg::t_word MIN_NEG = sid_pkg::t_word'(sid_pkg::SIGN_BIT);
    localparam sid_pkg::t_word MAX_VAL = sid_pkg::t_word'(sid_pkg::MAX_POS);

    // Operand corner values used by the random mix
    localparam sid_pkg::t_word CORNER_VALUES [6] = '{
        32'sd0, 32'sd1, -32'sd1, MIN_NEG, MAX_VAL, MIN_NEG + 32'sd1
    };

    typedef struct packed {
        sid_pkg::t_word quotient;
        logic           overflowed;
        logic           zero_divisor;
    } t_div_result;

    logic        clk;
    logic        rst_n;
    int unsigned cycle_count = 0;
    int unsigned error_count = 0;
    int unsigned sender_idle_pct = 22;
    int unsigned receiver_idle_pct = 70;

    t_div_result expected_quotients [$];

    sid_req_if req_ch ();
    sid_rsp_if rsp_ch ();

    signed_int32_divider_unit DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Clock
    initial begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    // Quotient truncated toward zero; MIN / -1 saturates, zero divisor flags
    function automatic t_div_result predict_division(input sid_pkg::t_word num,
                                                     input sid_pkg::t_word den);
        t_div_result res;
        logic [sid_pkg::DATA_W-1:0] mag_n;
        logic [sid_pkg::DATA_W-1:0] mag_d;
        logic [sid_pkg::DATA_W-1:0] mag_q;
        logic                       negative;
        res = '0;
        if (den == '0) begin
            res.zero_divisor = 1'b1;
            return res;
        end
        negative = num[sid_pkg::DATA_W-1] ^ den[sid_pkg::DATA_W-1];
        mag_n = num[sid_pkg::DATA_W-1] ? sid_pkg::DATA_W'(-num) : sid_pkg::DATA_W'(num);
        mag_d = den[sid_pkg::DATA_W-1] ? sid_pkg::DATA_W'(-den) : sid_pkg::DATA_W'(den);
        mag_q = mag_n / mag_d;
        if (!negative && mag_q > sid_pkg::MAX_POS) begin
            res.quotient   = MAX_VAL;
            res.overflowed = 1'b1;
        end else begin
            res.quotient = negative ? sid_pkg::t_word'(-mag_q) : sid_pkg::t_word'(mag_q);
        end
        return res;
    endfunction

    // Mix of full-range, short, tiny and corner operands
    function automatic sid_pkg::t_word random_operand();
        sid_pkg::t_word val;
        case ($urandom_range(9))
            0: val = CORNER_VALUES[$urandom_range(5)];
            1, 2: val = sid_pkg::t_word'($urandom_range(40)) - 32'sd20;
            3, 4: begin
                val = sid_pkg::t_word'($urandom >> $urandom_range(sid_pkg::DATA_W - 1));
                if ($urandom_range(1) == 1) val = -val;
            end
            default: val = sid_pkg::t_word'($urandom);
        endcase
        return val;
    endfunction

    // Send one division request; valid stays high after the accept
    task automatic send_division(input sid_pkg::t_word num, input sid_pkg::t_word den);
        while ($urandom_range(99) < sender_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.numerator   <= num;
        req_ch.denominator <= den;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        expected_quotients.push_back(predict_division(num, den));
    endtask

    // Hold off new requests until every outstanding result is back
    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_quotients.size() != 0) @(posedge clk);
    endtask

    // Corners: overflow, zero divisor, most negative operands, all sign combinations
    task automatic test_special_cases();
        send_division(MIN_NEG, -32'sd1);
        send_division(MIN_NEG, 32'sd1);
        send_division(MIN_NEG, MIN_NEG);
        send_division(MAX_VAL, MIN_NEG);
        send_division(-32'sd1, MIN_NEG);
        send_division(32'sd0, MIN_NEG);
        send_division(32'sd0, 32'sd0);
        send_division(MIN_NEG, 32'sd0);
        send_division(MAX_VAL, 32'sd0);
        send_division(-32'sd1, 32'sd0);
        send_division(MAX_VAL, MAX_VAL);
        send_division(MAX_VAL, -32'sd1);
        send_division(MAX_VAL, 32'sd1);
        send_division(MIN_NEG, 32'sd2);
        send_division(MIN_NEG, MAX_VAL);
        send_division(32'sd7, 32'sd2);
        send_division(-32'sd7, 32'sd2);
        send_division(32'sd7, -32'sd2);
        send_division(-32'sd7, -32'sd2);
        send_division(32'sd1, MAX_VAL);
        send_division(-32'sd1, -32'sd1);
        send_division(32'sd0, 32'sd5);
        send_division(MAX_VAL, -MAX_VAL);
        wait_for_results();
    endtask

    // Random operand pairs under the given idle mix
    task automatic test_random_division(input int unsigned send_pct,
                                        input int unsigned recv_pct);
        sid_pkg::t_word num;
        sid_pkg::t_word den;
        sender_idle_pct   = send_pct;
        receiver_idle_pct = recv_pct;
        repeat (PHASE_ITEMS) begin
            num = random_operand();
            den = ($urandom_range(24) == 0) ? sid_pkg::t_word'(0) : random_operand();
            send_division(num, den);
        end
    endtask

    // Response sink: random backpressure and result checks
    always @(posedge clk) begin
        t_div_result exp_res;
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (expected_quotients.size() == 0) begin
                $error("unexpected result: quotient %0d", rsp_ch.quotient);
                error_count++;
            end else begin
                exp_res = expected_quotients.pop_front();
                if (rsp_ch.quotient !== exp_res.quotient) begin
                    $error("quotient: expected %0d, got %0d",
                           exp_res.quotient, rsp_ch.quotient);
                    error_count++;
                end
                if (rsp_ch.overflowed !== exp_res.overflowed) begin
                    $error("overflowed: expected %0b, got %0b",
                           exp_res.overflowed, rsp_ch.overflowed);
                    error_count++;
                end
                if (rsp_ch.zero_divisor !== exp_res.zero_divisor) begin
                    $error("zero_divisor: expected %0b, got %0b",
                           exp_res.zero_divisor, rsp_ch.zero_divisor);
                    error_count++;
                end
            end
        end
        if (!rst_n) rsp_ch.ready <= 1'b0;
        else        rsp_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Test sequence
    initial begin
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.numerator   = '0;
        req_ch.denominator = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_special_cases();
        test_random_division(22, 70);
        test_random_division(70, 22);
        test_random_division(0, 0);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- signed_int32_divider_unit.f -----
sv/sid_pkg.sv
sv/sid_ifs.sv
sv/signed_int32_divider_unit.sv
tb/testbench.sv
